/* hdl/ppc_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the polygon plane clipper.
// -----------------------------------------------------------------------------
package ppc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] REG_NX  = 3'd0;
  localparam logic [2:0] REG_NY  = 3'd1;
  localparam logic [2:0] REG_NZ  = 3'd2;
  localparam logic [2:0] REG_OFS = 3'd3;
  localparam logic [2:0] REG_TOL = 3'd4;

  typedef logic [2:0][31:0] vec_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_RD,
    CMD_DSTEP,
    CMD_DFIN,
    CMD_PREV,
    CMD_DIVINIT,
    CMD_DIVSTEP,
    CMD_LSTEP,
    CMD_LFIN,
    CMD_CANDCUR,
    CMD_SQSTEP,
    CMD_SQCMP,
    CMD_KEEP,
    CMD_EMIT_P1,
    CMD_EMIT_P1_END,
    CMD_EMIT_P2_END,
    CMD_EMIT_EMPTY
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_DIST, S_PREV, S_EDGE, S_DIVI, S_DIVR, S_LERP, S_CUR,
    S_MCHK, S_SQ, S_MDEC, S_MEMIT, S_KEEP, S_FIN, S_FDEC, S_E1, S_E1END,
    S_E2, S_EMPTY
  } state_e;

  typedef struct packed {
    cmd_e          cmd;
    logic [1:0]    k;
    logic          sel;
    logic [AW-1:0] idx;
    logic          busy;
  } ctl_t;

  typedef struct packed {
    logic [CW-1:0] n;
    logic          cin;
    logic          pin;
    logic          far;
    logic          triv;
    logic [1:0]    nk;
    logic          out_free;
  } sts_t;

  function automatic logic [31:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        nd;
    d  = $signed({a[31], a}) - $signed({b[31], b});
    nd = 33'(-d);
    absd = d[32] ? nd[31:0] : d[31:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/ppc_ctrl.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ppc_ctrl
// Sequencer: walks the vertex store, edge division, lerp, merge and output.
// -----------------------------------------------------------------------------
module ppc_ctrl
  import ppc_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e        state_q, state_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;
  logic          init_q, init_d;
  logic          ret_q, ret_d;
  logic          fin_q, fin_d;
  logic [CW-1:0] nm1;

  assign nm1 = sts_i.n - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      init_q  <= 1'b0;
      ret_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      init_q  <= init_d;
      ret_q   <= ret_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    init_d    = init_q;
    ret_d     = ret_q;
    fin_d     = fin_q;
    ctl_o     = '0;
    ctl_o.cmd = CMD_NONE;
    ctl_o.busy = (state_q != S_IDLE);
    ctl_o.k   = cnt_q[1:0];
    ctl_o.sel = fin_q;
    ctl_o.idx = init_q ? nm1[AW-1:0] : i_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          init_d  = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        ctl_o.cmd = CMD_RD;
        cnt_d     = '0;
        state_d   = S_DIST;
      end
      S_DIST: begin
        ctl_o.cmd = (cnt_q == 5'd3) ? CMD_DFIN : CMD_DSTEP;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd3) state_d = init_q ? S_PREV : S_EDGE;
      end
      S_PREV: begin
        ctl_o.cmd = CMD_PREV;
        if (init_q) begin
          init_d  = 1'b0;
          state_d = S_RD;
        end else if (i_q == nm1) begin
          state_d = S_FIN;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_RD;
        end
      end
      S_EDGE: begin
        if (sts_i.cin != sts_i.pin) state_d = S_DIVI;
        else if (sts_i.cin) state_d = S_CUR;
        else state_d = S_PREV;
      end
      S_DIVI: begin
        ctl_o.cmd = CMD_DIVINIT;
        cnt_d     = '0;
        state_d   = S_DIVR;
      end
      S_DIVR: begin
        if (sts_i.triv) begin
          cnt_d   = '0;
          state_d = S_LERP;
        end else begin
          ctl_o.cmd = CMD_DIVSTEP;
          cnt_d     = cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_d = S_LERP;
        end
      end
      S_LERP: begin
        ctl_o.cmd = (cnt_q == 5'd3) ? CMD_LFIN : CMD_LSTEP;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          ret_d   = 1'b0;
          state_d = S_MCHK;
        end
      end
      S_CUR: begin
        ctl_o.cmd = CMD_CANDCUR;
        ret_d     = 1'b1;
        state_d   = S_MCHK;
      end
      S_MCHK: begin
        cnt_d = '0;
        fin_d = 1'b0;
        state_d = (sts_i.nk == 2'd0) ? S_KEEP : S_SQ;
      end
      S_SQ: begin
        ctl_o.cmd = (cnt_q == 5'd4) ? CMD_SQCMP : CMD_SQSTEP;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd4) state_d = fin_q ? S_FDEC : S_MDEC;
      end
      S_MDEC: begin
        if (sts_i.far) state_d = (sts_i.nk >= 2'd2) ? S_MEMIT : S_KEEP;
        else if (!ret_q && sts_i.cin) state_d = S_CUR;
        else state_d = S_PREV;
      end
      S_MEMIT: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = CMD_EMIT_P1;
          state_d   = S_KEEP;
        end
      end
      S_KEEP: begin
        ctl_o.cmd = CMD_KEEP;
        state_d   = (!ret_q && sts_i.cin) ? S_CUR : S_PREV;
      end
      S_FIN: begin
        cnt_d = '0;
        fin_d = 1'b1;
        case (sts_i.nk)
          2'd0:    state_d = S_EMPTY;
          2'd1:    state_d = S_E2;
          2'd2:    state_d = S_E1;
          default: state_d = S_SQ;
        endcase
      end
      S_FDEC: begin
        state_d = sts_i.far ? S_E1 : S_E1END;
      end
      S_E1: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = CMD_EMIT_P1;
          state_d   = S_E2;
        end
      end
      S_E1END: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = CMD_EMIT_P1_END;
          state_d   = S_IDLE;
        end
      end
      S_E2: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = CMD_EMIT_P2_END;
          state_d   = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = CMD_EMIT_EMPTY;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/ppc_dp.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ppc_dp
// Datapath: vertex store, shared multiplier, divider and output register.
// -----------------------------------------------------------------------------
module ppc_dp
  import ppc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_acc_i,
  input  wire  [31:0]        vert_x_i,
  input  wire  [31:0]        vert_y_i,
  input  wire  [31:0]        vert_z_i,
  input  wire                final_vertex_i,
  input  vec_t               nrm_i,
  input  wire  [63:0]        offset_i,
  input  wire  [31:0]        tol_i,
  input  ctl_t               ctl_i,
  output sts_t               sts_o,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output logic [31:0]        out_x_o,
  output logic [31:0]        out_y_o,
  output logic [31:0]        out_z_o,
  output logic               end_of_polygon_o,
  output logic               empty_result_o,
  output logic               overflow_o
);

  logic [95:0]   mem [MAX_VERTICES];
  logic [CW-1:0] count_q, n_q;
  logic          ovf_q, povf_q, full;
  vec_t          cur_q, prev_q, cand_q, first_q, p1_q, p2_q;
  logic signed [67:0] dcur_q, dprev_q, acc_q, lim, psx;
  logic          pin_q, far_q, triv_q, cin;
  logic signed [65:0] prod_q;
  logic signed [32:0] ma, mb;
  logic [65:0]   sum_q;
  logic [32:0]   t_q;
  logic [69:0]   r_q, dd_q, r2;
  logic signed [69:0] num, den;
  logic [69:0]   an, ad;
  logic [1:0]    nk_q, kk, jj;
  logic          out_valid_q, out_free;
  logic [31:0]   lres;
  logic          end_q, empty_q, oovf_q;
  vec_t          out_q;

  assign kk   = ctl_i.k;
  assign full = (count_q == CW'(MAX_VERTICES));
  assign lim  = $signed({20'd0, tol_i, 16'd0});
  assign cin  = (dcur_q <= lim);
  assign psx  = {{2{prod_q[65]}}, prod_q};
  assign out_free = !out_valid_q || !out_stall_i;

  assign num = -{{2{dprev_q[67]}}, dprev_q};
  assign den = {{2{dcur_q[67]}}, dcur_q} - {{2{dprev_q[67]}}, dprev_q};
  assign an  = num[69] ? 70'(-num) : num;
  assign ad  = den[69] ? 70'(-den) : den;
  assign r2  = {r_q[68:0], 1'b0};

  assign jj = (ctl_i.cmd == CMD_LFIN) ? 2'd2 : kk - 2'd1;

  always_comb begin
    logic signed [32:0] d;
    logic [31:0] q;
    d = $signed({cur_q[jj][31], cur_q[jj]}) - $signed({prev_q[jj][31], prev_q[jj]});
    q = prod_q[63:32];
    if (t_q[32]) lres = cur_q[jj];
    else if (d[32]) lres = prev_q[jj] - (q + {31'd0, (prod_q[31:0] != 32'd0)});
    else lres = prev_q[jj] + q;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl_i.cmd)
      CMD_DSTEP: begin
        ma = {nrm_i[kk][31], nrm_i[kk]};
        mb = {cur_q[kk][31], cur_q[kk]};
      end
      CMD_LSTEP: begin
        ma = {1'b0, absd(cur_q[kk], prev_q[kk])};
        mb = {1'b0, t_q[31:0]};
      end
      CMD_SQSTEP: begin
        if (kk == 2'd3) begin
          ma = {1'b0, tol_i};
        end else if (ctl_i.sel) begin
          ma = {1'b0, absd(first_q[kk], p2_q[kk])};
        end else begin
          ma = {1'b0, absd(cand_q[kk], p2_q[kk])};
        end
        mb = ma;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && !full) mem[count_q[AW-1:0]] <= {vert_x_i, vert_y_i, vert_z_i};
    if (ctl_i.cmd == CMD_RD) begin
      cur_q[0] <= mem[ctl_i.idx][95:64];
      cur_q[1] <= mem[ctl_i.idx][63:32];
      cur_q[2] <= mem[ctl_i.idx][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    case (ctl_i.cmd)
      CMD_DSTEP: acc_q <= (kk == 2'd0) ? -{{4{offset_i[63]}}, offset_i} : acc_q + psx;
      CMD_DFIN:  dcur_q <= acc_q + psx;
      CMD_PREV: begin
        prev_q  <= cur_q;
        dprev_q <= dcur_q;
      end
      CMD_DIVINIT: begin
        r_q  <= an;
        dd_q <= ad;
        if (den == 70'sd0) begin
          t_q <= (num > 70'sd0) ? 33'h1_0000_0000 : 33'd0;
        end else if (num == 70'sd0 || num[69] != den[69]) begin
          t_q <= 33'd0;
        end else if (an >= ad) begin
          t_q <= 33'h1_0000_0000;
        end else begin
          t_q <= 33'd0;
        end
      end
      CMD_DIVSTEP: begin
        if (r2 >= dd_q) begin
          r_q <= r2 - dd_q;
          t_q <= {t_q[31:0], 1'b1};
        end else begin
          r_q <= r2;
          t_q <= {t_q[31:0], 1'b0};
        end
      end
      CMD_LSTEP: if (kk != 2'd0) cand_q[jj] <= lres;
      CMD_LFIN:  cand_q[jj] <= lres;
      CMD_CANDCUR: cand_q <= cur_q;
      CMD_SQSTEP: sum_q <= (kk == 2'd0) ? 66'd0 : sum_q + {2'd0, prod_q[63:0]};
      CMD_SQCMP:  far_q <= (sum_q > {2'd0, prod_q[63:0]});
      CMD_KEEP: begin
        if (nk_q == 2'd0) first_q <= cand_q;
        p1_q <= p2_q;
        p2_q <= cand_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      n_q     <= '0;
      povf_q  <= 1'b0;
      nk_q    <= '0;
      pin_q   <= 1'b0;
      triv_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc_i) begin
        if (final_vertex_i) begin
          n_q     <= full ? count_q : count_q + CW'(1);
          povf_q  <= ovf_q | full;
          count_q <= '0;
          ovf_q   <= 1'b0;
          nk_q    <= '0;
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
      if (ctl_i.cmd == CMD_PREV) pin_q <= cin;
      if (ctl_i.cmd == CMD_DIVINIT) begin
        triv_q <= (den == 70'sd0) || (num == 70'sd0) || (num[69] != den[69]) || (an >= ad);
      end
      if (ctl_i.cmd == CMD_KEEP && nk_q != 2'd3) nk_q <= nk_q + 2'd1;
      case (ctl_i.cmd)
        CMD_EMIT_P1, CMD_EMIT_P1_END, CMD_EMIT_P2_END, CMD_EMIT_EMPTY:
          out_valid_q <= 1'b1;
        default: if (!out_stall_i) out_valid_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CMD_EMIT_P1: begin
        out_q <= p1_q; end_q <= 1'b0; empty_q <= 1'b0; oovf_q <= povf_q;
      end
      CMD_EMIT_P1_END: begin
        out_q <= p1_q; end_q <= 1'b1; empty_q <= 1'b0; oovf_q <= povf_q;
      end
      CMD_EMIT_P2_END: begin
        out_q <= p2_q; end_q <= 1'b1; empty_q <= 1'b0; oovf_q <= povf_q;
      end
      CMD_EMIT_EMPTY: begin
        out_q <= '0; end_q <= 1'b1; empty_q <= 1'b1; oovf_q <= povf_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o          = '0;
    sts_o.n        = n_q;
    sts_o.cin      = cin;
    sts_o.pin      = pin_q;
    sts_o.far      = far_q;
    sts_o.triv     = triv_q;
    sts_o.nk       = nk_q;
    sts_o.out_free = out_free;
  end

  assign out_valid_o      = out_valid_q;
  assign out_x_o          = out_q[0];
  assign out_y_o          = out_q[1];
  assign out_z_o          = out_q[2];
  assign end_of_polygon_o = end_q;
  assign empty_result_o   = empty_q;
  assign overflow_o       = oovf_q;

endmodule
`default_nettype wire

/* hdl/polygon_plane_clipper.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// polygon_plane_clipper
// Clips one polygon against the half-space n.q - c <= eps.
// Usage: vertices enter on the in channel (valid/stall), one transaction per
// cycle while the block is idle; final_vertex_i marks the last one and starts
// clipping. in_stall_o stays high until the last result of the polygon has
// been loaded into the output register. Results leave on the out channel,
// end_of_polygon_o on the last; a fully clipped polygon gives one result with
// empty_result_o set. Each vertex walked is read, its plane distance taken and
// its bookkeeping done; each candidate is checked against the last kept vertex
// (the first kept skips it; an emit follows when a check releases a result),
// and an edge crossing runs the 32-step bit-serial divider (skipped when t is
// trivially 0 or 1) and the single shared 33x33 multiplier. A stalled
// receiver holds the output register and the sequencer waits at the next
// emit. Reset empties the vertex store count and loads the register defaults;
// no clearing pass is needed. Plane and tolerance must be written over APB
// only while the block is idle; the block itself does not enforce this.
// -----------------------------------------------------------------------------
module polygon_plane_clipper
  import ppc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [31:0] vert_x_i,
  input  wire  [31:0] vert_y_i,
  input  wire  [31:0] vert_z_i,
  input  wire         final_vertex_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        end_of_polygon_o,
  output logic        empty_result_o,
  output logic        overflow_o
);

  vec_t        nrm_q;
  logic [63:0] ofs_q;
  logic [31:0] tol_q;
  logic        in_acc;
  ctl_t        ctl;
  sts_t        sts;

  assign pready = 1'b1;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = ctl.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= {32'd65536, 32'd0, 32'd0};
      ofs_q <= '0;
      tol_q <= 32'd66;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_NX:  nrm_q[0] <= pwdata[31:0];
        REG_NY:  nrm_q[1] <= pwdata[31:0];
        REG_NZ:  nrm_q[2] <= pwdata[31:0];
        REG_OFS: ofs_q    <= pwdata;
        REG_TOL: tol_q    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_NX:  prdata = {32'd0, nrm_q[0]};
      REG_NY:  prdata = {32'd0, nrm_q[1]};
      REG_NZ:  prdata = {32'd0, nrm_q[2]};
      REG_OFS: prdata = ofs_q;
      REG_TOL: prdata = {32'd0, tol_q};
      default: prdata = '0;
    endcase
  end

  ppc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && final_vertex_i),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  ppc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_acc_i         (in_acc),
    .vert_x_i         (vert_x_i),
    .vert_y_i         (vert_y_i),
    .vert_z_i         (vert_z_i),
    .final_vertex_i   (final_vertex_i),
    .nrm_i            (nrm_q),
    .offset_i         (ofs_q),
    .tol_i            (tol_q),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o),
    .end_of_polygon_o (end_of_polygon_o),
    .empty_result_o   (empty_result_o),
    .overflow_o       (overflow_o)
  );

endmodule
`default_nettype wire

/* test/clip_checker.sv */
// -----------------------------------------------------------------------------
// clip_checker
// Watches the APB port and both channels of the polygon plane clipper, keeps
// its own copy of the plane registers and vertex store, predicts the clipped
// vertex list of each polygon and compares every output transaction field by
// field against the oldest predicted vertex.
// -----------------------------------------------------------------------------
module clip_checker
  import ppc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  input  wire         pready,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire  [31:0] vert_x_i,
  input  wire  [31:0] vert_y_i,
  input  wire  [31:0] vert_z_i,
  input  wire         final_vertex_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire  [31:0] out_x_i,
  input  wire  [31:0] out_y_i,
  input  wire  [31:0] out_z_i,
  input  wire         end_of_polygon_i,
  input  wire         empty_result_i,
  input  wire         overflow_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        eop;
    logic        empty;
    logic        ovf;
  } clip_vert_t;

  typedef logic signed [127:0] wide_t;

  clip_vert_t         clipped_q[$];
  longint             vstore[MAX_VERTICES][3];
  int unsigned        vcount;
  bit                 ovf_seen;
  logic signed [31:0] nx, ny, nz;
  logic signed [63:0] ofs;
  logic [31:0]        tol;

  assign pending_o = clipped_q.size();

  function automatic wide_t plane_dist(longint x, longint y, longint z);
    wide_t wx, wy, wz, a, b, c, o;
    wx = x; wy = y; wz = z;
    a = nx; b = ny; c = nz; o = ofs;
    return a * wx + b * wy + c * wz - o;
  endfunction

  function automatic bit far_apart(longint a[3], longint b[3]);
    wide_t sum, d, e;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = a[k] - b[k];
      sum += d * d;
    end
    e = {96'b0, tol};
    e = e * e;
    return sum > e;
  endfunction

  function automatic logic [32:0] cross_frac(wide_t da, wide_t db);
    wide_t num, den;
    logic [127:0] un, ud;
    num = -da;
    den = db - da;
    if (den == 0) return (num > 0) ? 33'h1_0000_0000 : 33'd0;
    if (num == 0 || ((num < 0) != (den < 0))) return 33'd0;
    if (num < 0) begin
      num = -num;
      den = -den;
    end
    if (num >= den) return 33'h1_0000_0000;
    un = num;
    ud = den;
    un = (un << 32) / ud;
    return {1'b0, un[31:0]};
  endfunction

  function automatic longint lerp1(longint a, longint b, logic [32:0] t);
    wide_t d, tt, p;
    if (t[32]) return b;
    d  = b - a;
    tt = {95'b0, t};
    p  = (d * tt) >>> 32;
    return a + longint'(p);
  endfunction

  task automatic predict_polygon();
    longint      raw[2*MAX_VERTICES][3];
    longint      kept[2*MAX_VERTICES][3];
    longint      cur[3];
    longint      last[3];
    wide_t       dvals[MAX_VERTICES];
    wide_t       lim;
    int unsigned n, nraw, nk, prev;
    bit          pin, cin, ovf;
    logic [32:0] t;
    clip_vert_t  v;
    n = vcount;
    ovf = ovf_seen;
    vcount = 0;
    ovf_seen = 0;
    nraw = 0;
    nk = 0;
    lim = {96'b0, tol};
    lim = lim << 16;
    for (int i = 0; i < n; i++)
      dvals[i] = plane_dist(vstore[i][0], vstore[i][1], vstore[i][2]);
    if (n > 0) begin
      prev = n - 1;
      pin = dvals[prev] <= lim;
      for (int i = 0; i < n; i++) begin
        cin = dvals[i] <= lim;
        if (cin != pin) begin
          t = cross_frac(dvals[prev], dvals[i]);
          for (int k = 0; k < 3; k++) raw[nraw][k] = lerp1(vstore[prev][k], vstore[i][k], t);
          nraw++;
        end
        if (cin) begin
          for (int k = 0; k < 3; k++) raw[nraw][k] = vstore[i][k];
          nraw++;
        end
        prev = i;
        pin = cin;
      end
    end
    for (int i = 0; i < nraw; i++) begin
      for (int k = 0; k < 3; k++) cur[k] = raw[i][k];
      if (nk > 0) for (int k = 0; k < 3; k++) last[k] = kept[nk-1][k];
      if (nk == 0 || far_apart(cur, last)) begin
        for (int k = 0; k < 3; k++) kept[nk][k] = cur[k];
        nk++;
      end
    end
    if (nk >= 3) begin
      for (int k = 0; k < 3; k++) begin
        cur[k] = kept[0][k];
        last[k] = kept[nk-1][k];
      end
      if (!far_apart(cur, last)) nk--;
    end
    if (nk == 0) begin
      v = '{x: '0, y: '0, z: '0, eop: 1'b1, empty: 1'b1, ovf: ovf};
      clipped_q.insert(clipped_q.size(), v);
    end
    for (int i = 0; i < nk; i++) begin
      v.x = kept[i][0][31:0];
      v.y = kept[i][1][31:0];
      v.z = kept[i][2][31:0];
      v.eop = (i + 1 == nk);
      v.empty = 1'b0;
      v.ovf = ovf;
      clipped_q.insert(clipped_q.size(), v);
    end
  endtask

  task automatic report(string what, clip_vert_t got, clip_vert_t want);
    $display({"%0t mismatch %s: got x=%h y=%h z=%h eop=%b empty=%b ovf=%b,",
              " want x=%h y=%h z=%h eop=%b empty=%b ovf=%b"},
             $realtime, what, got.x, got.y, got.z, got.eop, got.empty, got.ovf,
             want.x, want.y, want.z, want.eop, want.empty, want.ovf);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    clip_vert_t got, want;
    if (!rst_ni) begin
      vcount = 0;
      ovf_seen = 0;
      nx = '0;
      ny = '0;
      nz = 32'sd65536;
      ofs = '0;
      tol = 32'd66;
      clipped_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_NX:  nx = pwdata[31:0];
          REG_NY:  ny = pwdata[31:0];
          REG_NZ:  nz = pwdata[31:0];
          REG_OFS: ofs = pwdata;
          REG_TOL: tol = pwdata[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (vcount < MAX_VERTICES) begin
          vstore[vcount][0] = longint'($signed(vert_x_i));
          vstore[vcount][1] = longint'($signed(vert_y_i));
          vstore[vcount][2] = longint'($signed(vert_z_i));
          vcount++;
        end else begin
          ovf_seen = 1;
        end
        if (final_vertex_i) predict_polygon();
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{x: out_x_i, y: out_y_i, z: out_z_i, eop: end_of_polygon_i,
                empty: empty_result_i, ovf: overflow_i};
        if (clipped_q.size() == 0) begin
          report("unexpected transaction", got, '0);
        end else begin
          want = clipped_q.pop_front();
          if (got != want) report("vertex", got, want);
        end
      end
    end
  end

endmodule

/* test/tb.sv */
// -----------------------------------------------------------------------------
// tb
// Drives polygons into the polygon plane clipper under several plane and
// tolerance settings, with random gaps on the input and random stalls on the
// output, and gives the verdict from the checker's mismatch count.
// -----------------------------------------------------------------------------
module tb
  import ppc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] vert_x_i = '0, vert_y_i = '0, vert_z_i = '0;
  logic        final_vertex_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  logic        end_of_polygon_o, empty_result_o, overflow_o;
  int          fail_count, pending;
  int          cycles = 0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          gaps_on = 1;
  int          vert_total = 0;
  logic [31:0] px, py, pz;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polygon_plane_clipper dut (.*);

  clip_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_i(in_stall_o), .vert_x_i, .vert_y_i, .vert_z_i,
    .final_vertex_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .end_of_polygon_i(end_of_polygon_o), .empty_result_i(empty_result_o),
    .overflow_i(overflow_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("polygon_plane_clipper verification failed");
      $finish;
    end
  end

  // receiver: random stall runs, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(0, 2) == 0);
      run_left = pick_gap();
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic fin);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    vert_x_i = x;
    vert_y_i = y;
    vert_z_i = z;
    final_vertex_i = fin;
    do @(posedge clk_i); while (in_stall_o);
    vert_total++;
  endtask

  task automatic send_polygon(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && r < 12) begin
        px += $urandom_range(0, 3) - 1;
        py += $urandom_range(0, 3) - 1;
        pz += $urandom_range(0, 3) - 1;
      end else if (r < 22) begin
        px = $urandom;
        py = $urandom;
        pz = $urandom;
      end else begin
        px = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        py = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        pz = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      end
      send_vertex(px, py, pz, i == n - 1);
    end
  endtask

  task automatic random_polygons(int count);
    int r, n, start;
    start = vert_total;
    while (vert_total - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 6) n = $urandom_range(1, 2);
      else if (r < 14) n = $urandom_range(17, 20);
      else n = $urandom_range(3, 8);
      send_polygon(n);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset plane z <= eps
    send_vertex(32'h0001_0000, 32'h0, 32'hFFFF_0000, 0);
    send_vertex(32'h0, 32'h0001_0000, 32'hFFFE_0000, 0);
    send_vertex(32'hFFFF_0000, 32'h0, 32'hFFFF_8000, 1);
    send_vertex(32'h0, 32'h0, 32'h0002_0000, 0);
    send_vertex(32'h0001_0000, 32'h0, 32'h0003_0000, 0);
    send_vertex(32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 1);
    send_vertex(32'h0, 32'h0, 32'hFFFF_0000, 0);
    send_vertex(32'h0001_0000, 32'h0, 32'hFFFF_0000, 0);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send_vertex(32'h0, 32'h0001_0000, 32'h0001_0000, 1);
    send_vertex(32'h0, 32'h0, 32'h0, 1);
    send_vertex(32'h0, 32'h0, 32'h0000_0042, 0);
    send_vertex(32'h0, 32'h0, 32'h0000_0043, 1);
    send_vertex(32'h0, 32'h0, 32'hFFFF_0000, 0);
    send_vertex(32'h0, 32'h0, 32'hFFFF_0001, 0);
    send_vertex(32'h0002_0000, 32'h0, 32'hFFFF_0000, 0);
    send_vertex(32'h0, 32'h0002_0000, 32'hFFFF_0000, 0);
    send_vertex(32'h0, 32'h0, 32'hFFFF_0020, 1);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_vertex(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1);
    random_polygons(14);
    drain();

    // long hold-off at the receiver while polygons keep coming
    hold_left = 500;
    random_polygons(14);
    drain();

    apb_write(REG_NX, 64'h0001_0000);
    apb_write(REG_NY, 64'hFFFF_0000);
    apb_write(REG_NZ, 64'h0);
    apb_write(REG_OFS, 64'h0000_0000_8000_0000);
    apb_write(REG_TOL, 64'h0);
    random_polygons(14);
    drain();

    apb_write(REG_NX, 64'h8000_0000);
    apb_write(REG_NY, 64'h7FFF_FFFF);
    apb_write(REG_OFS, 64'h8000_0000_0000_0000);
    random_polygons(6);
    drain();

    apb_write(REG_OFS, 64'h7FFF_FFFF_FFFF_FFFF);
    apb_write(REG_TOL, 64'hFFFF_FFFF);
    random_polygons(6);
    drain();

    gaps_on = 0;
    apb_write(REG_NX, {32'h0, 32'($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000)});
    apb_write(REG_NY, {32'h0, 32'($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000)});
    apb_write(REG_NZ, {32'h0, 32'($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000)});
    apb_write(REG_OFS, {{12{1'b0}}, 20'($urandom), $urandom} - 64'h0008_0000_0000_0000);
    apb_write(REG_TOL, {32'h0, 32'($urandom_range(0, 4095))});
    random_polygons(14);
    drain();

    gaps_on = 1;
    apb_write(REG_NX, 64'h0);
    apb_write(REG_NY, 64'h0000_8000);
    apb_write(REG_NZ, 64'h0001_0000);
    apb_write(REG_OFS, 64'h0);
    apb_write(REG_TOL, 64'd66);
    random_polygons(14);
    drain();

    if (fail_count == 0) begin
      $display("polygon_plane_clipper verification clean");
    end else begin
      $display("polygon_plane_clipper verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ppc_pkg.sv
hdl/ppc_ctrl.sv
hdl/ppc_dp.sv
hdl/polygon_plane_clipper.sv
test/clip_checker.sv
test/tb.sv
